[rtl/core/rnc_pkg.sv]
package rnc_pkg;

  // Largest number of colour centres the block is built for
  localparam int MAX_CENTERS = 8;

  // Field widths
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int INDEX_W  = 3;
  localparam int DIST_W   = 10;
  localparam int NUM_W    = 4;
  localparam int REG_W    = 48;
  localparam int REG_IDX_W = 3;
  localparam int NUM_CENTER_REGS = 4;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_CLUSTERS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTERS_0_1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTERS_2_3  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTERS_4_5  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTERS_6_7  = 3'd4;

  // Reset value of the active centre count
  localparam logic [NUM_W-1:0] NUM_CLUSTERS_RESET = 4'd1;

  // Data handed from one cell to the next
  typedef struct packed {
    logic [CHAN_W-1:0]  pix_red;
    logic [CHAN_W-1:0]  pix_green;
    logic [CHAN_W-1:0]  pix_blue;
    logic [INDEX_W-1:0] best_index;
    logic [COLOR_W-1:0] best_color;
    logic [DIST_W-1:0]  best_distance;
  } stage_t;

  // Absolute difference of two channel values
  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] res;
    if (a >= b) begin
      res = a - b;
    end else begin
      res = b - a;
    end
    return res;
  endfunction

endpackage

[rtl/core/rnc_pix_if.sv]
interface rnc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rnc_pkg::CHAN_W-1:0] pix_red;
  logic [rnc_pkg::CHAN_W-1:0] pix_green;
  logic [rnc_pkg::CHAN_W-1:0] pix_blue;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  input ready);
  modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                  output ready);
endinterface

[rtl/core/rnc_res_if.sv]
interface rnc_res_if;
  logic                        valid;
  logic                        ready;
  logic [rnc_pkg::INDEX_W-1:0] nearest_index;
  logic [rnc_pkg::CHAN_W-1:0]  out_red;
  logic [rnc_pkg::CHAN_W-1:0]  out_green;
  logic [rnc_pkg::CHAN_W-1:0]  out_blue;
  logic [rnc_pkg::DIST_W-1:0]  best_distance;

  modport source (output valid, output nearest_index, output out_red, output out_green,
                  output out_blue, output best_distance, input ready);
  modport sink   (input valid, input nearest_index, input out_red, input out_green,
                  input out_blue, input best_distance, output ready);
endinterface

[rtl/core/rnc_cfg_if.sv]
interface rnc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rnc_pkg::REG_IDX_W-1:0] reg_index;
  logic [rnc_pkg::REG_W-1:0]     reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

[rtl/core/rnc_cell.sv]
module rnc_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rnc_pkg::stage_t               in_data,
  input  logic [rnc_pkg::COLOR_W-1:0]   center,
  input  logic                          active,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rnc_pkg::stage_t               out_data
);

  logic [rnc_pkg::DIST_W-1:0] distance;
  logic                       take;
  rnc_pkg::stage_t            data_next;

  // L1 distance of the passing pixel to this cell's centre
  assign distance = rnc_pkg::DIST_W'(rnc_pkg::absdiff(in_data.pix_red,   center[7:0]))
                  + rnc_pkg::DIST_W'(rnc_pkg::absdiff(in_data.pix_green, center[15:8]))
                  + rnc_pkg::DIST_W'(rnc_pkg::absdiff(in_data.pix_blue,  center[23:16]));

  // First cell always seeds the best; later cells win only on a strict improvement
  assign take = (INDEX == 0) || (active && (distance < in_data.best_distance));

  always_comb begin
    data_next = in_data;
    if (take) begin
      data_next.best_index    = rnc_pkg::INDEX_W'(INDEX);
      data_next.best_color    = center;
      data_next.best_distance = distance;
    end
  end

  // Advance when this stage is empty or its beat leaves this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/core/rgb_nearest_center_l1.sv]
// Nearest colour centre by L1 distance, one cell per centre in a chain.
// Each accepted pixel beat passes through every cell's register, in chain order, to its result beat.
// Throughput: one pixel per cycle; each cell registers the running best and hands it on.
// A stalled result holds the chain; upstream cells keep filling their empty slots.
// Reset (rst, synchronous): pipeline emptied, num_clusters = 1, all centres = 0.
module rgb_nearest_center_l1 #(
  parameter int MAX_CENTERS = rnc_pkg::MAX_CENTERS
) (
  input  logic        clk,
  input  logic        rst,
  rnc_pix_if.sink     pix,
  rnc_res_if.source   res,
  rnc_cfg_if.sink     cfg
);

  logic [rnc_pkg::NUM_W-1:0] num_clusters;
  logic [rnc_pkg::REG_W-1:0] centers [rnc_pkg::NUM_CENTER_REGS];

  logic            stage_valid [MAX_CENTERS+1];
  logic            stage_ready [MAX_CENTERS+1];
  rnc_pkg::stage_t stage_data  [MAX_CENTERS+1];

  // Configuration registers; always ready, unknown indexes dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= rnc_pkg::NUM_CLUSTERS_RESET;
      for (int i = 0; i < rnc_pkg::NUM_CENTER_REGS; i++) begin
        centers[i] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        rnc_pkg::REG_NUM_CLUSTERS: num_clusters <= cfg.reg_data[rnc_pkg::NUM_W-1:0];
        rnc_pkg::REG_CENTERS_0_1:  centers[0]   <= cfg.reg_data;
        rnc_pkg::REG_CENTERS_2_3:  centers[1]   <= cfg.reg_data;
        rnc_pkg::REG_CENTERS_4_5:  centers[2]   <= cfg.reg_data;
        rnc_pkg::REG_CENTERS_6_7:  centers[3]   <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  // Chain entry: pixel beat with an empty best
  assign stage_valid[0] = pix.valid;
  assign pix.ready      = stage_ready[0];

  always_comb begin
    stage_data[0]               = '0;
    stage_data[0].pix_red       = pix.pix_red;
    stage_data[0].pix_green     = pix.pix_green;
    stage_data[0].pix_blue      = pix.pix_blue;
  end

  // One cell per centre
  for (genvar k = 0; k < MAX_CENTERS; k++) begin : g_cell
    logic active;

    assign active = num_clusters > rnc_pkg::NUM_W'(k);

    rnc_cell #(
      .INDEX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_data   (stage_data[k]),
      .center    (centers[k/2][(k%2)*rnc_pkg::COLOR_W +: rnc_pkg::COLOR_W]),
      .active    (active),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  // Last cell's register is the result register
  assign stage_ready[MAX_CENTERS] = res.ready;
  assign res.valid         = stage_valid[MAX_CENTERS];
  assign res.nearest_index = stage_data[MAX_CENTERS].best_index;
  assign res.out_red       = stage_data[MAX_CENTERS].best_color[7:0];
  assign res.out_green     = stage_data[MAX_CENTERS].best_color[15:8];
  assign res.out_blue      = stage_data[MAX_CENTERS].best_color[23:16];
  assign res.best_distance = stage_data[MAX_CENTERS].best_distance;

endmodule

[test/rnc_checker.sv]
module rnc_checker
  import rnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rnc_pix_if   pix,
  rnc_res_if   res,
  rnc_cfg_if   cfg,
  output int   fault_total,
  output int   matches_due
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [DIST_W-1:0]  distance;
  } match_t;

  // Shadow copy of the colour centre registers
  logic [NUM_W-1:0]   cluster_count;
  logic [COLOR_W-1:0] centre_col [MAX_CENTERS];

  match_t awaited_matches [$];
  int     fault_count = 0;

  function automatic int chan_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Nearest active centre by L1 distance; the lowest index keeps a tie
  function automatic match_t nearest_centre(input logic [CHAN_W-1:0] r,
                                            input logic [CHAN_W-1:0] g,
                                            input logic [CHAN_W-1:0] b);
    match_t best;
    int     used;
    int     d;
    used = int'(cluster_count);
    if (used == 0) used = 1;
    if (used > MAX_CENTERS) used = MAX_CENTERS;
    best = '0;
    for (int k = 0; k < used; k++) begin
      d = chan_gap(r, centre_col[k][7:0]) + chan_gap(g, centre_col[k][15:8])
        + chan_gap(b, centre_col[k][23:16]);
      if (k == 0 || d < int'(best.distance)) begin
        best.index    = INDEX_W'(k);
        best.red      = centre_col[k][7:0];
        best.green    = centre_col[k][15:8];
        best.blue     = centre_col[k][23:16];
        best.distance = DIST_W'(d);
      end
    end
    return best;
  endfunction

  // Track register writes, check result beats, then queue predictions for pixel beats
  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (rst) begin
      cluster_count = NUM_CLUSTERS_RESET;
      foreach (centre_col[k]) centre_col[k] = '0;
      awaited_matches.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_NUM_CLUSTERS: cluster_count = cfg.reg_data[NUM_W-1:0];
          REG_CENTERS_0_1: begin
            centre_col[0] = cfg.reg_data[23:0];
            centre_col[1] = cfg.reg_data[47:24];
          end
          REG_CENTERS_2_3: begin
            centre_col[2] = cfg.reg_data[23:0];
            centre_col[3] = cfg.reg_data[47:24];
          end
          REG_CENTERS_4_5: begin
            centre_col[4] = cfg.reg_data[23:0];
            centre_col[5] = cfg.reg_data[47:24];
          end
          REG_CENTERS_6_7: begin
            centre_col[6] = cfg.reg_data[23:0];
            centre_col[7] = cfg.reg_data[47:24];
          end
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        got.index    = res.nearest_index;
        got.red      = res.out_red;
        got.green    = res.out_green;
        got.blue     = res.out_blue;
        got.distance = res.best_distance;
        if (awaited_matches.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result beat: idx %0d rgb %h %h %h dist %0d",
                     got.index, got.red, got.green, got.blue, got.distance);
        end else begin
          want = awaited_matches.pop_front();
          if (got.index !== want.index || got.red !== want.red || got.green !== want.green
              || got.blue !== want.blue || got.distance !== want.distance) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"result mismatch: expected idx %0d rgb %h %h %h dist %0d,",
                        " got idx %0d rgb %h %h %h dist %0d"},
                       want.index, want.red, want.green, want.blue, want.distance,
                       got.index, got.red, got.green, got.blue, got.distance);
          end
        end
      end

      if (pix.valid && pix.ready)
        awaited_matches.push_back(nearest_centre(pix.pix_red, pix.pix_green, pix.pix_blue));
    end
    fault_total <= fault_count;
    matches_due <= awaited_matches.size();
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import rnc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = MAX_CENTERS + 4;
  localparam int HOLD_CYCLES = 150;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rnc_pix_if pix ();
  rnc_res_if res ();
  rnc_cfg_if cfg ();

  int fault_total;
  int matches_due;

  rgb_nearest_center_l1 uut (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg));

  rnc_checker chk (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg),
                   .fault_total(fault_total), .matches_due(matches_due));

  // Centres as last written, used to aim pixels at or between them
  logic [COLOR_W-1:0] palette [MAX_CENTERS];

  int hold_reqs = 0;
  int holds_done = 0;
  int cycles = 0;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: ready follows a changing pattern, with long hold-offs on request
  initial begin : result_sink
    int   mode;
    int   left;
    int   held;
    logic rdy;
    mode = 0;
    left = 0;
    held = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rdy = 1'b0;
      end else if (hold_reqs != holds_done) begin
        rdy = 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          holds_done++;
          held = 0;
        end
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 1) == 1);
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((left % 5) < 2);
        endcase
      end
      res.ready <= rdy;
    end
  end

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] c);
    pix.valid     <= 1'b1;
    pix.pix_red   <= c[7:0];
    pix.pix_green <= c[15:8];
    pix.pix_blue  <= c[23:16];
    do @(posedge clk); while (!pix.ready);
  endtask

  // Hold until every predicted result has left the block
  task automatic wait_drained();
    do @(posedge clk); while (matches_due != 0);
  endtask

  task automatic write_centres();
    put_reg(REG_CENTERS_0_1, {palette[1], palette[0]});
    put_reg(REG_CENTERS_2_3, {palette[3], palette[2]});
    put_reg(REG_CENTERS_4_5, {palette[5], palette[4]});
    put_reg(REG_CENTERS_6_7, {palette[7], palette[6]});
  endtask

  // Fill the palette: random, saturated rails, duplicates, all equal, or a tight group
  task automatic load_centres(input int style);
    for (int k = 0; k < MAX_CENTERS; k++) begin
      palette[k] = 24'($urandom());
      case (style)
        1: for (int ch = 0; ch < 3; ch++)
             palette[k][ch*CHAN_W +: CHAN_W] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        2: if (k > 0 && $urandom_range(0, 1) == 1) palette[k] = palette[$urandom_range(0, k-1)];
        3: if (k > 0) palette[k] = palette[0];
        4: if (k > 0)
             for (int ch = 0; ch < 3; ch++)
               palette[k][ch*CHAN_W +: CHAN_W] =
                 palette[0][ch*CHAN_W +: CHAN_W] + 8'($urandom_range(0, 12));
        default: ;
      endcase
    end
    write_centres();
  endtask

  // Mostly random pixels; the rest sit on, near or halfway between centres, or on the rails
  function automatic logic [COLOR_W-1:0] pick_pixel();
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] pixel;
    int                 v;
    a = palette[$urandom_range(0, MAX_CENTERS-1)];
    b = palette[$urandom_range(0, MAX_CENTERS-1)];
    pixel = 24'($urandom());
    case ($urandom_range(0, 9))
      5, 6: for (int ch = 0; ch < 3; ch++) begin
              v = int'(a[ch*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 16)) - 8;
              v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
              pixel[ch*CHAN_W +: CHAN_W] = CHAN_W'(v);
            end
      7: pixel = a;
      8: for (int ch = 0; ch < 3; ch++)
           pixel[ch*CHAN_W +: CHAN_W] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      9: for (int ch = 0; ch < 3; ch++)
           pixel[ch*CHAN_W +: CHAN_W] =
             CHAN_W'((int'(a[ch*CHAN_W +: CHAN_W]) + int'(b[ch*CHAN_W +: CHAN_W])) / 2);
      default: ;
    endcase
    return pixel;
  endfunction

  // Offer pixels in bursts with random gaps; steady runs send without a break
  task automatic run_items(input int count, input bit steady);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = steady ? count : $urandom_range(1, 40);
      send_pixel(pick_pixel());
      burst--;
      if (burst == 0 && i < count - 1) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          pix.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    pix.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int               cluster_plan [12];
    logic [REG_W-1:0] word;
    cluster_plan = '{8, 0, 15, 1, 3, 8, 5, 2, 9, 7, 4, 6};
    rst           <= 1'b1;
    pix.valid     <= 1'b0;
    pix.pix_red   <= '0;
    pix.pix_green <= '0;
    pix.pix_blue  <= '0;
    cfg.valid     <= 1'b0;
    cfg.reg_index <= REG_NUM_CLUSTERS;
    cfg.reg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: one black centre, distance from zero up to full scale
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h8000FF);
    pix.valid <= 1'b0;
    wait_drained();

    // All eight centres on the colour cube corners, one duplicated to force a tie
    palette = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                24'hFF0000, 24'h0000FF, 24'h00FFFF, 24'hFF00FF};
    put_reg(REG_NUM_CLUSTERS, 48'd8);
    write_centres();
    cfg.valid <= 1'b0;
    for (int k = 0; k < MAX_CENTERS; k++) send_pixel(palette[k]);
    send_pixel(24'h808080);
    pix.valid <= 1'b0;
    wait_drained();

    // Writes to unmapped indexes must change nothing
    put_reg(REG_SPARE_LO, '1);
    put_reg(REG_SPARE_LO + 3'd1, {16'($urandom()), $urandom()});
    put_reg(REG_SPARE_HI, '0);
    cfg.valid <= 1'b0;
    send_pixel(24'hFFFFFF);
    pix.valid <= 1'b0;
    wait_drained();

    // Zero clusters behaves as one
    put_reg(REG_NUM_CLUSTERS, 48'd0);
    cfg.valid <= 1'b0;
    send_pixel(24'hFFFFFF);
    pix.valid <= 1'b0;
    wait_drained();

    // Count above the maximum saturates; upper data bits are dropped
    put_reg(REG_NUM_CLUSTERS, {44'hABC_DEF0_1234, 4'hF});
    cfg.valid <= 1'b0;
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FFFF);
    pix.valid <= 1'b0;
    wait_drained();

    put_reg(REG_NUM_CLUSTERS, 48'd2);
    cfg.valid <= 1'b0;
    send_pixel(24'h0000FF);
    pix.valid <= 1'b0;

    // Random phases, each with a fresh setting
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      word = {16'($urandom()), $urandom()};
      word[NUM_W-1:0] = NUM_W'(cluster_plan[ph]);
      put_reg(REG_NUM_CLUSTERS, word);
      load_centres(ph % 5);
      if (ph % 4 == 1)
        put_reg(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                {16'($urandom()), $urandom()});
      cfg.valid <= 1'b0;
      if (ph == 5 || ph == 10) hold_reqs++;
      if (ph == 8) begin
        run_items(64, 1'b0);
        wait_drained();
        run_items(64, 1'b0);
      end else begin
        run_items(128, ph == 3);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_total == 0 && matches_due == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

[files.f]
rtl/core/rnc_pkg.sv
rtl/core/rnc_pix_if.sv
rtl/core/rnc_res_if.sv
rtl/core/rnc_cfg_if.sv
rtl/core/rnc_cell.sv
rtl/core/rgb_nearest_center_l1.sv
test/rnc_checker.sv
test/tb_top.sv
